// ===== sv/prf_pkg.sv =====
`timescale 1ns / 1ps

package prf_pkg;

  // fixed point format of positions
  localparam int PosFracBits = 24;

  // field and datapath widths
  localparam int PosW   = 32;
  localparam int RadW   = 25;
  localparam int ImW    = 32;
  localparam int CfgW   = 32;
  localparam int MagW   = 25;
  localparam int SqW    = 2 * MagW;
  localparam int R2W    = SqW + 1;
  localparam int CSqW   = 2 * RadW;
  localparam int RootW  = SqW / 2;
  localparam int RemW   = RootW + 3;
  localparam int ScaleW = RadW + ImW;
  localparam int ScLoW  = 32;
  localparam int ScHiW  = ScaleW - ScLoW;
  localparam int DenW   = RootW + SqW;
  localparam int PrdW   = ScaleW + MagW;
  localparam int NumW   = PrdW + PosFracBits;
  localparam int QW     = 48;
  localparam int ForceW = 48;

  // pipeline depth of each part
  localparam int GeomLat  = 4;
  localparam int SqrtLat  = RootW;
  localparam int CoefLat  = 6;
  localparam int DivLat   = QW;
  localparam int FinalLat = 1;
  localparam int Latency  = GeomLat + SqrtLat + CoefLat + DivLat + FinalLat;

  // saturation limits of the signed result
  localparam logic [ForceW-1:0] ForcePosMax = {1'b0, {(ForceW-1){1'b1}}};
  localparam logic [ForceW-1:0] ForceNegMax = {1'b1, {(ForceW-1){1'b0}}};

  // register indexes
  localparam logic [1:0] RegCutoff  = 2'd0;
  localparam logic [1:0] RegMinRad  = 2'd1;
  localparam logic [1:0] RegInvMass = 2'd2;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [RadW-1:0] cutoff;
    logic [CSqW-1:0] cutoff_sq;
    logic [CSqW-1:0] min_sq;
    logic [ImW-1:0]  inv_mass;
  } cfg_t;

  // geometry of one pair after clamping
  typedef struct packed {
    logic            in_range;
    logic            neg_x;
    logic            neg_y;
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
    logic [SqW-1:0]  r2c;
  } geom_t;

  // flags travelling with one component through the divider
  typedef struct packed {
    logic in_range;
    logic neg;
    logic ovf;
  } div_side_t;

  // one component handed to the divider
  typedef struct packed {
    div_side_t       side;
    logic [QW-1:0]   num_lo;
    logic [DenW-1:0] rem;
    logic [DenW-1:0] den;
  } div_in_t;

endpackage

// ===== sv/pair_repulsive_force.sv =====
`timescale 1ns / 1ps

// Short-range repulsive pair force. Each transfer on start carries the Q8.24
// positions of a particle and one neighbour; after the pipeline below done_o
// is high for one cycle with the Q32.16 force, in_range_o and saturated_o.
// busy is always low: a new pair may start in every cycle, one result per
// pair comes out in order, and the receiver has no way to stall the stream,
// so every result must be taken in the cycle it is shown. The latency is set
// by the pipeline: 4 geometry stages, 25 square root stages (one root bit
// each), 6 coefficient stages and 48 divider stages (one quotient bit each)
// and the output register. Configuration writes are always ready and must
// only be made while no pair is in flight.
module pair_repulsive_force (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [prf_pkg::PosW-1:0]          self_x_i,
  input  logic [prf_pkg::PosW-1:0]          self_y_i,
  input  logic [prf_pkg::PosW-1:0]          other_x_i,
  input  logic [prf_pkg::PosW-1:0]          other_y_i,
  output logic                              done_o,
  output logic signed [prf_pkg::ForceW-1:0] force_x_o,
  output logic signed [prf_pkg::ForceW-1:0] force_y_o,
  output logic                              in_range_o,
  output logic                              saturated_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [prf_pkg::CfgW-1:0]          cfg_data_i
);
  import prf_pkg::*;

  // configuration registers and their squares
  logic [RadW-1:0] cutoff_q, min_rad_q;
  logic [ImW-1:0]  inv_mass_q;
  logic [CSqW-1:0] cutoff_sq_q, min_sq_q;
  cfg_t            cfg;

  logic      geom_valid, sqrt_valid, coef_valid, divx_valid, divy_valid;
  geom_t     geom, geom_s;
  logic [RootW-1:0] root;
  div_in_t   div_x, div_y;
  div_side_t side_x, side_y;
  logic [QW-1:0] quo_x, quo_y;

  logic              sat_x, sat_y;
  logic [ForceW-1:0] fx_d, fy_d;
  logic              done_q;
  logic [ForceW-1:0] fx_q, fy_q;
  logic              in_range_q, sat_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= RadW'(167772);
      min_rad_q  <= RadW'(1678);
      inv_mass_q <= ImW'(6553600);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCutoff:  cutoff_q   <= cfg_data_i[RadW-1:0];
        RegMinRad:  min_rad_q  <= cfg_data_i[RadW-1:0];
        RegInvMass: inv_mass_q <= cfg_data_i[ImW-1:0];
        default: ;
      endcase
    end
  end

  // squared radii, refreshed in the cycle after a write
  always_ff @(posedge clk_i) begin
    cutoff_sq_q <= cutoff_q * cutoff_q;
    min_sq_q    <= min_rad_q * min_rad_q;
  end

  assign cfg.cutoff    = cutoff_q;
  assign cfg.cutoff_sq = cutoff_sq_q;
  assign cfg.min_sq    = min_sq_q;
  assign cfg.inv_mass  = inv_mass_q;

  prf_geom u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .self_x_i  (self_x_i),
    .self_y_i  (self_y_i),
    .other_x_i (other_x_i),
    .other_y_i (other_y_i),
    .cfg_i     (cfg),
    .valid_o   (geom_valid),
    .geom_o    (geom)
  );

  prf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geom_valid),
    .geom_i  (geom),
    .valid_o (sqrt_valid),
    .geom_o  (geom_s),
    .root_o  (root)
  );

  prf_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sqrt_valid),
    .geom_i  (geom_s),
    .root_i  (root),
    .cfg_i   (cfg),
    .valid_o (coef_valid),
    .div_x_o (div_x),
    .div_y_o (div_y)
  );

  prf_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_valid),
    .div_i   (div_x),
    .valid_o (divx_valid),
    .side_o  (side_x),
    .quo_o   (quo_x)
  );

  prf_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_valid),
    .div_i   (div_y),
    .valid_o (divy_valid),
    .side_o  (side_y),
    .quo_o   (quo_y)
  );

  // sign and saturation of each component
  always_comb begin
    sat_x = side_x.ovf || (side_x.neg ? (quo_x > ForceNegMax) : quo_x[QW-1]);
    sat_y = side_y.ovf || (side_y.neg ? (quo_y > ForceNegMax) : quo_y[QW-1]);
    if (sat_x) begin
      fx_d = side_x.neg ? ForceNegMax : ForcePosMax;
    end else begin
      fx_d = side_x.neg ? (~quo_x + 1'b1) : quo_x;
    end
    if (sat_y) begin
      fy_d = side_y.neg ? ForceNegMax : ForcePosMax;
    end else begin
      fy_d = side_y.neg ? (~quo_y + 1'b1) : quo_y;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= divx_valid && divy_valid;
    end
  end

  // result payload, zero when out of range
  always_ff @(posedge clk_i) begin
    in_range_q <= side_x.in_range;
    if (side_x.in_range) begin
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      sat_q <= sat_x || sat_y;
    end else begin
      fx_q  <= '0;
      fy_q  <= '0;
      sat_q <= 1'b0;
    end
  end

  assign done_o      = done_q;
  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign in_range_o  = in_range_q;
  assign saturated_o = sat_q;

endmodule

// ===== sv/prf_geom.sv =====
`timescale 1ns / 1ps

module prf_geom (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [prf_pkg::PosW-1:0] self_x_i,
  input  logic [prf_pkg::PosW-1:0] self_y_i,
  input  logic [prf_pkg::PosW-1:0] other_x_i,
  input  logic [prf_pkg::PosW-1:0] other_y_i,
  input  prf_pkg::cfg_t            cfg_i,
  output logic                     valid_o,
  output prf_pkg::geom_t           geom_o
);
  import prf_pkg::*;

  logic [GeomLat-1:0] valid_q;

  // stage 1: differences and magnitudes
  logic [PosW:0]   dx, dy;
  logic [PosW-1:0] adx_d, ady_d, adx_q, ady_q;
  logic            nx_q, ny_q;

  // stage 2: per axis squares
  logic            ok_d, ok_q;
  logic [SqW-1:0]  ax2_q, ay2_q;
  logic            nx2_q, ny2_q;
  logic [MagW-1:0] mx2_q, my2_q;

  // stage 3: distance squared against cutoff
  logic [R2W-1:0]  r2_d, r2_q;
  logic            in_d, in_q;
  logic            nx3_q, ny3_q;
  logic [MagW-1:0] mx3_q, my3_q;

  // stage 4: clamp
  logic [SqW-1:0]  r2c_d;
  geom_t           geom_q;

  assign dx    = {1'b0, other_x_i} - {1'b0, self_x_i};
  assign dy    = {1'b0, other_y_i} - {1'b0, self_y_i};
  assign adx_d = dx[PosW] ? (~dx[PosW-1:0] + 1'b1) : dx[PosW-1:0];
  assign ady_d = dy[PosW] ? (~dy[PosW-1:0] + 1'b1) : dy[PosW-1:0];

  assign ok_d = (adx_q <= {{(PosW-RadW){1'b0}}, cfg_i.cutoff}) &&
                (ady_q <= {{(PosW-RadW){1'b0}}, cfg_i.cutoff});

  assign r2_d = {1'b0, ax2_q} + {1'b0, ay2_q};
  assign in_d = ok_q && (r2_d <= {{(R2W-CSqW){1'b0}}, cfg_i.cutoff_sq});

  // clamp below at min radius squared, zero distance counts as one lsb
  always_comb begin
    r2c_d = r2_q[SqW-1:0];
    if (r2_q[SqW-1:0] < {{(SqW-CSqW){1'b0}}, cfg_i.min_sq}) begin
      r2c_d = {{(SqW-CSqW){1'b0}}, cfg_i.min_sq};
    end
    if (r2c_d == '0) begin
      r2c_d = {{(SqW-1){1'b0}}, 1'b1};
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[GeomLat-2:0], valid_i};
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    adx_q <= adx_d;
    ady_q <= ady_d;
    nx_q  <= dx[PosW];
    ny_q  <= dy[PosW];

    ok_q  <= ok_d;
    ax2_q <= adx_q[MagW-1:0] * adx_q[MagW-1:0];
    ay2_q <= ady_q[MagW-1:0] * ady_q[MagW-1:0];
    nx2_q <= nx_q;
    ny2_q <= ny_q;
    mx2_q <= adx_q[MagW-1:0];
    my2_q <= ady_q[MagW-1:0];

    r2_q  <= r2_d;
    in_q  <= in_d;
    nx3_q <= nx2_q;
    ny3_q <= ny2_q;
    mx3_q <= mx2_q;
    my3_q <= my2_q;

    geom_q.in_range <= in_q;
    geom_q.neg_x    <= nx3_q;
    geom_q.neg_y    <= ny3_q;
    geom_q.mag_x    <= mx3_q;
    geom_q.mag_y    <= my3_q;
    geom_q.r2c      <= r2c_d;
  end

  assign valid_o = valid_q[GeomLat-1];
  assign geom_o  = geom_q;

endmodule

// ===== sv/prf_sqrt.sv =====
`timescale 1ns / 1ps

module prf_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  prf_pkg::geom_t            geom_i,
  output logic                      valid_o,
  output prf_pkg::geom_t            geom_o,
  output logic [prf_pkg::RootW-1:0] root_o
);
  import prf_pkg::*;

  logic [SqrtLat-1:0] valid_q;
  logic [RemW-1:0]    rem_q  [SqrtLat];
  logic [RootW-1:0]   root_q [SqrtLat];
  geom_t              geom_q [SqrtLat];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SqrtLat-2:0], valid_i};
    end
  end

  // one root bit per stage, most significant first
  for (genvar s = 0; s < SqrtLat; s++) begin : g_stage
    localparam int K = SqrtLat - 1 - s;
    logic [RemW-1:0]  rem_in, rem_sh, trial, rem_d;
    logic [RootW-1:0] root_in, root_d;
    geom_t            geom_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign geom_in = geom_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign geom_in = geom_q[s-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], geom_in.r2c[2*K+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
      geom_q[s] <= geom_in;
    end
  end

  assign valid_o = valid_q[SqrtLat-1];
  assign geom_o  = geom_q[SqrtLat-1];
  assign root_o  = root_q[SqrtLat-1];

endmodule

// ===== sv/prf_coef.sv =====
`timescale 1ns / 1ps

module prf_coef (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  prf_pkg::geom_t            geom_i,
  input  logic [prf_pkg::RootW-1:0] root_i,
  input  prf_pkg::cfg_t             cfg_i,
  output logic                      valid_o,
  output prf_pkg::div_in_t          div_x_o,
  output prf_pkg::div_in_t          div_y_o
);
  import prf_pkg::*;

  typedef struct packed {
    logic            in_range;
    logic            neg_x;
    logic            neg_y;
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
  } side_t;

  logic [CoefLat-1:0] valid_q;

  // stage 1: distance to cutoff
  logic             cneg;
  logic [RadW-1:0]  diff_d, diff_q;
  logic [RootW-1:0] root1_q;
  logic [SqW-1:0]   r2c1_q;
  side_t            side1_q;

  // stage 2: scale and denominator partials
  logic [ScaleW-1:0] scale2_q;
  logic [SqW-1:0]    dlo_q, dhi_q;
  side_t             side2_q;

  // stage 3: denominator
  logic [ScaleW-1:0] scale3_q;
  logic [DenW-1:0]   den3_q;
  side_t             side3_q;

  // stage 4: numerator partials
  logic [ScaleW-1:0]     pxl_q, pyl_q;
  logic [ScHiW+MagW-1:0] pxh_q, pyh_q;
  logic [DenW-1:0]       den4_q;
  side_t                 side4_q;

  // stage 5: numerators
  logic [PrdW-1:0] prdx, prdy;
  logic [NumW-1:0] numx_q, numy_q;
  logic [DenW-1:0] den5_q;
  side_t           side5_q;

  // stage 6: overflow check
  div_in_t divx_q, divy_q;

  assign cneg   = root_i < cfg_i.cutoff;
  assign diff_d = cneg ? (cfg_i.cutoff - root_i) : (root_i - cfg_i.cutoff);

  assign prdx = {{(PrdW-ScaleW){1'b0}}, pxl_q} + {pxh_q, {ScLoW{1'b0}}};
  assign prdy = {{(PrdW-ScaleW){1'b0}}, pyl_q} + {pyh_q, {ScLoW{1'b0}}};

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[CoefLat-2:0], valid_i};
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    diff_q           <= diff_d;
    root1_q          <= root_i;
    r2c1_q           <= geom_i.r2c;
    side1_q.in_range <= geom_i.in_range;
    side1_q.neg_x    <= geom_i.neg_x ^ cneg;
    side1_q.neg_y    <= geom_i.neg_y ^ cneg;
    side1_q.mag_x    <= geom_i.mag_x;
    side1_q.mag_y    <= geom_i.mag_y;

    scale2_q <= diff_q * cfg_i.inv_mass;
    dlo_q    <= root1_q * r2c1_q[RootW-1:0];
    dhi_q    <= root1_q * r2c1_q[SqW-1:RootW];
    side2_q  <= side1_q;

    scale3_q <= scale2_q;
    den3_q   <= {{(DenW-SqW){1'b0}}, dlo_q} + {dhi_q, {RootW{1'b0}}};
    side3_q  <= side2_q;

    pxl_q   <= scale3_q[ScLoW-1:0] * side3_q.mag_x;
    pxh_q   <= scale3_q[ScaleW-1:ScLoW] * side3_q.mag_x;
    pyl_q   <= scale3_q[ScLoW-1:0] * side3_q.mag_y;
    pyh_q   <= scale3_q[ScaleW-1:ScLoW] * side3_q.mag_y;
    den4_q  <= den3_q;
    side4_q <= side3_q;

    numx_q  <= {prdx, {PosFracBits{1'b0}}};
    numy_q  <= {prdy, {PosFracBits{1'b0}}};
    den5_q  <= den4_q;
    side5_q <= side4_q;

    // quotient of 2^48 or more shows as high numerator bits at or above den
    divx_q.side.in_range <= side5_q.in_range;
    divx_q.side.neg      <= side5_q.neg_x;
    divx_q.side.ovf      <= {{(DenW-(NumW-QW)){1'b0}}, numx_q[NumW-1:QW]} >= den5_q;
    divx_q.num_lo        <= numx_q[QW-1:0];
    divx_q.rem           <= {{(DenW-(NumW-QW)){1'b0}}, numx_q[NumW-1:QW]};
    divx_q.den           <= den5_q;

    divy_q.side.in_range <= side5_q.in_range;
    divy_q.side.neg      <= side5_q.neg_y;
    divy_q.side.ovf      <= {{(DenW-(NumW-QW)){1'b0}}, numy_q[NumW-1:QW]} >= den5_q;
    divy_q.num_lo        <= numy_q[QW-1:0];
    divy_q.rem           <= {{(DenW-(NumW-QW)){1'b0}}, numy_q[NumW-1:QW]};
    divy_q.den           <= den5_q;
  end

  assign valid_o = valid_q[CoefLat-1];
  assign div_x_o = divx_q;
  assign div_y_o = divy_q;

endmodule

// ===== sv/prf_div.sv =====
`timescale 1ns / 1ps

module prf_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  prf_pkg::div_in_t       div_i,
  output logic                   valid_o,
  output prf_pkg::div_side_t     side_o,
  output logic [prf_pkg::QW-1:0] quo_o
);
  import prf_pkg::*;

  logic [DivLat-1:0] valid_q;
  logic [DenW-1:0]   rem_q  [DivLat];
  logic [DenW-1:0]   den_q  [DivLat];
  logic [QW-1:0]     num_q  [DivLat];
  logic [QW-1:0]     quo_q  [DivLat];
  div_side_t         side_q [DivLat];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DivLat-2:0], valid_i};
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < DivLat; s++) begin : g_stage
    localparam int J = DivLat - 1 - s;
    logic [DenW-1:0] rem_in, den_in, rem_d;
    logic [QW-1:0]   num_in, quo_in, quo_d;
    logic [DenW:0]   rem_sh, rem_sub;
    div_side_t       side_in;

    if (s == 0) begin : g_first
      assign rem_in  = div_i.rem;
      assign den_in  = div_i.den;
      assign num_in  = div_i.num_lo;
      assign quo_in  = '0;
      assign side_in = div_i.side;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign num_in  = num_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign rem_sh  = {rem_in, num_in[J]};
    assign rem_sub = rem_sh - {1'b0, den_in};

    always_comb begin
      if (rem_sh >= {1'b0, den_in}) begin
        rem_d = rem_sub[DenW-1:0];
        quo_d = {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DenW-1:0];
        quo_d = {quo_in[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      den_q[s]  <= den_in;
      num_q[s]  <= num_in;
      quo_q[s]  <= quo_d;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = valid_q[DivLat-1];
  assign side_o  = side_q[DivLat-1];
  assign quo_o   = quo_q[DivLat-1];

endmodule

// ===== sv/prf_checker.sv =====
`timescale 1ns / 1ps

module prf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic signed [prf_pkg::ForceW-1:0] force_x_o,
  input logic signed [prf_pkg::ForceW-1:0] force_y_o,
  input logic                              in_range_o,
  input logic                              saturated_o
);
  import prf_pkg::*;

  // every accepted pair yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("result missing after accepted pair");

  // pairs beyond the cutoff give a zero force and no clipping
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_range_o) |-> (force_x_o == '0 && force_y_o == '0 && !saturated_o))
    else $error("nonzero force outside cutoff");

  // a clipped result holds a limit value in at least one component
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (force_x_o == ForcePosMax || force_x_o == ForceNegMax ||
       force_y_o == ForcePosMax || force_y_o == ForceNegMax))
    else $error("saturation flag without limit value");

endmodule

bind pair_repulsive_force prf_checker u_prf_checker (.*);

// ===== tb/tb_pair_repulsive_force.sv =====
`timescale 1ns / 1ps

module tb_pair_repulsive_force;
  import prf_pkg::*;

  typedef struct {
    logic [ForceW-1:0] fx;
    logic [ForceW-1:0] fy;
    logic              in_range;
    logic              sat;
  } force_t;

  // room for every pair that can be in flight at once
  localparam int ExpDepth = 128;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [PosW-1:0]   self_x_i, self_y_i, other_x_i, other_y_i;
  logic              done_o;
  logic signed [ForceW-1:0] force_x_o, force_y_o;
  logic              in_range_o, saturated_o;
  logic              cfg_valid_i, cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [CfgW-1:0]   cfg_data_i;

  // shadow of the register file
  logic [RadW-1:0] sh_cutoff;
  logic [RadW-1:0] sh_min_rad;
  logic [ImW-1:0]  sh_inv_mass;

  force_t expected_forces [ExpDepth];
  int     exp_wr;
  int     exp_rd;
  int     n_pairs_taken;
  int     n_cfg_taken;
  int     n_errors;
  int     idle_pct;

  pair_repulsive_force u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // integer square root, floor
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= {64'd0, v}) root = trial;
    end
    return root[63:0];
  endfunction

  // one saturated signed component
  function automatic logic [ForceW-1:0] force_part(logic [63:0] scale, logic neg,
                                                   logic [32:0] mag, logic [127:0] den,
                                                   inout logic sat);
    logic [127:0] num;
    logic [127:0] quo;
    num = ({64'd0, scale} * {95'd0, mag}) << PosFracBits;
    quo = num / den;
    if (neg) begin
      if (quo > 128'h8000_0000_0000) begin
        sat = 1'b1;
        return ForceNegMax;
      end
      return -quo[ForceW-1:0];
    end
    if (quo > 128'h7FFF_FFFF_FFFF) begin
      sat = 1'b1;
      return ForcePosMax;
    end
    return quo[ForceW-1:0];
  endfunction

  // expected force for one pair under the current registers
  function automatic force_t pair_force(logic [PosW-1:0] sx, logic [PosW-1:0] sy,
                                        logic [PosW-1:0] ox, logic [PosW-1:0] oy);
    force_t res;
    logic signed [33:0] dx, dy;
    logic [32:0] adx, ady;
    logic [63:0] c, r2, m2, ri, diff, scale;
    logic [127:0] den;
    logic coef_neg, sat;
    res = '{fx: '0, fy: '0, in_range: 1'b0, sat: 1'b0};
    sat = 1'b0;
    dx = $signed({2'b0, ox}) - $signed({2'b0, sx});
    dy = $signed({2'b0, oy}) - $signed({2'b0, sy});
    adx = dx < 0 ? 33'(-dx) : 33'(dx);
    ady = dy < 0 ? 33'(-dy) : 33'(dy);
    c = {39'd0, sh_cutoff};
    if (adx > c || ady > c) return res;
    r2 = adx * adx + ady * ady;
    if (r2 > c * c) return res;
    m2 = {39'd0, sh_min_rad} * {39'd0, sh_min_rad};
    if (r2 < m2) r2 = m2;
    if (r2 == 0) r2 = 1;
    ri = int_sqrt(r2);
    coef_neg = ri < c;
    diff = coef_neg ? c - ri : ri - c;
    scale = diff * {32'd0, sh_inv_mass};
    den = {64'd0, ri} * {64'd0, r2};
    res.fx = force_part(scale, coef_neg != (dx < 0), adx, den, sat);
    res.fy = force_part(scale, coef_neg != (dy < 0), ady, den, sat);
    res.in_range = 1'b1;
    res.sat = sat;
    return res;
  endfunction

  // input transfers and register writes, seen before the edge updates
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      expected_forces[exp_wr % ExpDepth] =
        pair_force(self_x_i, self_y_i, other_x_i, other_y_i);
      exp_wr++;
      n_pairs_taken++;
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCutoff:  sh_cutoff = cfg_data_i[RadW-1:0];
        RegMinRad:  sh_min_rad = cfg_data_i[RadW-1:0];
        RegInvMass: sh_inv_mass = cfg_data_i[ImW-1:0];
        default: ;
      endcase
      n_cfg_taken++;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    force_t want;
    if (rst_ni && done_o) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected result fx=%h fy=%h", $time, force_x_o, force_y_o);
        n_errors++;
      end else begin
        want = expected_forces[exp_rd % ExpDepth];
        exp_rd++;
        if (force_x_o !== want.fx) begin
          $display("%0t: force_x exp %h got %h", $time, want.fx, force_x_o);
          n_errors++;
        end
        if (force_y_o !== want.fy) begin
          $display("%0t: force_y exp %h got %h", $time, want.fy, force_y_o);
          n_errors++;
        end
        if (in_range_o !== want.in_range) begin
          $display("%0t: in_range exp %b got %b", $time, want.in_range, in_range_o);
          n_errors++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t: saturated exp %b got %b", $time, want.sat, saturated_o);
          n_errors++;
        end
      end
    end
  end

  // one pair transfer, with random idle cycles ahead of it
  task automatic send_pair(logic [PosW-1:0] sx, logic [PosW-1:0] sy,
                           logic [PosW-1:0] ox, logic [PosW-1:0] oy);
    int seen;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start     <= 1'b1;
    self_x_i  <= sx;
    self_y_i  <= sy;
    other_x_i <= ox;
    other_y_i <= oy;
    seen = n_pairs_taken;
    wait (n_pairs_taken != seen);
  endtask

  // let the pipeline drain completely
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    wait (exp_wr == exp_rd);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] data);
    int seen;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    seen = n_cfg_taken;
    wait (n_cfg_taken != seen);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [CfgW-1:0] cut, logic [CfgW-1:0] mn, logic [CfgW-1:0] im);
    drain();
    write_reg(RegCutoff, cut);
    write_reg(RegMinRad, mn);
    write_reg(RegInvMass, im);
  endtask

  // directed corners: coincident, at the cutoff, beyond it, wraparound, clamp
  task automatic test_directed();
    logic [PosW-1:0] c;
    idle_pct = 0;
    c = {7'd0, sh_cutoff};
    send_pair(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000);
    send_pair(32'h1000_0000, 32'h2000_0000, 32'h1000_0000 + c, 32'h2000_0000);
    send_pair(32'h1000_0000, 32'h2000_0000, 32'h1000_0000 - c, 32'h2000_0000);
    send_pair(32'h1000_0000, 32'h2000_0000, 32'h1000_0000 + c + 1, 32'h2000_0000);
    send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_pair(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF - (c >> 2), c >> 3);
    send_pair(32'h0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFE);
    send_pair(32'h5000_0000, 32'h5000_0000, 32'h5000_0000 + (c >> 1),
              32'h5000_0000 + (c >> 1));
    send_pair(32'h5000_0000, 32'h5000_0000, 32'h5000_0000 + (c >> 1) + 1,
              32'h5000_0000 + (c >> 1) + 1);
    // saturation with a huge inverse mass at close range
    set_regs(32'h0100_0000, 32'd1, 32'hFFFF_FFFF);
    send_pair(32'h4000_0000, 32'h4000_0000, 32'h4000_0001, 32'h4000_0000);
    send_pair(32'h4000_0000, 32'h4000_0000, 32'h3FFF_FFFF, 32'h3FFF_FFFE);
    send_pair(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
    send_pair(32'h4000_0000, 32'h4000_0000, 32'h4100_0000, 32'h4000_0000);
    // zero min radius, coincident pair
    set_regs(32'h0000_1000, 32'd0, 32'h0001_0000);
    send_pair(32'h7777_7777, 32'h1234_5678, 32'h7777_7777, 32'h1234_5678);
    send_pair(32'h7777_7777, 32'h1234_5678, 32'h7777_7778, 32'h1234_5678);
    // clamp beyond cutoff
    set_regs(32'h0000_0100, 32'h0100_0000, 32'h0000_8000);
    send_pair(32'h2000_0000, 32'h2000_0000, 32'h2000_0010, 32'h1FFF_FFF0);
    send_pair(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0100);
    // zero inverse mass and zero cutoff
    set_regs(32'h0001_0000, 32'd16, 32'd0);
    send_pair(32'h2000_0000, 32'h2000_0000, 32'h2000_0100, 32'h2000_0000);
    set_regs(32'd0, 32'd0, 32'h0001_0000);
    send_pair(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000);
    send_pair(32'h2000_0000, 32'h2000_0000, 32'h2000_0001, 32'h2000_0000);
  endtask

  // mostly neighbours near the cutoff, some fully random positions
  task automatic test_random(int count, int pct);
    logic [PosW-1:0] sx, sy;
    logic [33:0] span;
    logic signed [33:0] ox, oy;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      sx = $urandom;
      sy = $urandom;
      span = (34'(sh_cutoff) * 5 >> 2) + 1;
      if (i % 3 == 0) span = 34'(sh_cutoff) + 1;
      if ($urandom_range(9) == 0) begin
        send_pair(sx, sy, $urandom, $urandom);
      end else begin
        ox = $signed({2'b0, sx}) + $signed(34'($urandom_range(span[31:0]))) *
             ($urandom_range(1) ? 1 : -1);
        oy = $signed({2'b0, sy}) + $signed(34'($urandom_range(span[31:0]))) *
             ($urandom_range(1) ? 1 : -1);
        send_pair(sx, sy, ox[31:0], oy[31:0]);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    self_x_i = '0;
    self_y_i = '0;
    other_x_i = '0;
    other_y_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegCutoff;
    cfg_data_i = '0;
    sh_cutoff = 25'd167772;
    sh_min_rad = 25'd1678;
    sh_inv_mass = 32'd6553600;
    exp_wr = 0;
    exp_rd = 0;
    n_pairs_taken = 0;
    n_cfg_taken = 0;
    n_errors = 0;
    idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_random(60, 0);
    test_directed();
    set_regs(32'd167772, 32'd1678, 32'd6553600);
    test_random(100, 59);
    set_regs(32'h0100_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    test_random(100, 0);
    set_regs(32'h0000_0001, 32'h0100_0000, 32'h0000_0001);
    test_random(60, 15);
    set_regs(32'h0004_0000, 32'h0000_4000, 32'h0010_0000);
    test_random(120, 59);
    set_regs(32'd1 + $urandom_range(32'hFF_FFFF), 32'd1 + $urandom_range(32'hFFFF),
             32'd1 + $urandom);
    test_random(110, 15);

    drain();
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
